// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the parser checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Single property, sampled on the rising clock, off while reset is active
`define OLP_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define OLP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/olp_pkg.sv
// ----------------------------------------------------------------------------
// olp_pkg
// Shared types and constants for the octal word line parser.
// ----------------------------------------------------------------------------
package olp_pkg;

	// Default configuration
	localparam int DIGITS_PER_LINE_DEF = 3;
	localparam int WORD_BITS_DEF       = 12;

	// Fixed field widths
	localparam int CHAR_W   = 8;
	localparam int STATUS_W = 3;
	localparam int LINE_W   = 16;
	localparam int TAG_W    = 6;
	localparam int WORD_W   = 12;

	// Character codes
	localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
	localparam logic [CHAR_W-1:0] CH_SEVEN   = 8'h37;
	localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
	localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;

	// Operation codes of an input beat
	localparam logic OP_CHAR = 1'b0;
	localparam logic OP_EOF  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 3'd0,
		ST_NON_OCTAL  = 3'd1,
		ST_TOO_MANY   = 3'd2,
		ST_TOO_FEW    = 3'd3,
		ST_INCOMPLETE = 3'd4
	} status_t;

	// One result beat
	typedef struct packed {
		status_t               status;
		logic [LINE_W-1:0]     line_number;
		logic [TAG_W-1:0]      tag;
		logic [WORD_W-1:0]     word;
	} result_t;

endpackage

// File: hdl/olp_parse.sv
// ----------------------------------------------------------------------------
// olp_parse
// Parser state and per-character update: digit collection, line counting,
// record assembly and error detection. Result is combinational on step.
// ----------------------------------------------------------------------------
module olp_parse #(
	parameter int DIGITS_PER_LINE = olp_pkg::DIGITS_PER_LINE_DEF,
	parameter int WORD_BITS       = olp_pkg::WORD_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic                        op,
	input  logic [olp_pkg::CHAR_W-1:0]  char_code,
	output logic                        res_valid,
	output olp_pkg::result_t            res
);
	import olp_pkg::*;

	localparam int ADDR_BITS = 3 * (DIGITS_PER_LINE - 1);
	localparam int FULL_BITS = 2 * ADDR_BITS;
	localparam int CNT_W     = $clog2(DIGITS_PER_LINE + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DIGITS_PER_LINE);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

	logic                 second_q,  n_second;
	logic [CNT_W-1:0]     cnt_q,     n_cnt;
	logic [2:0]           tag1_q,    n_tag1;
	logic [2:0]           tag2_q,    n_tag2;
	logic [ADDR_BITS-1:0] hi_q,      n_hi;
	logic [ADDR_BITS-1:0] lo_q,      n_lo;
	logic [LINE_W-1:0]    line_q,    n_line;
	logic [LINE_W-1:0]    line_inc;
	logic [FULL_BITS-1:0] full_word;
	logic [WORD_W-1:0]    word_asm;
	logic [2:0]           digit;

	// Record word: first line high, second line low, cut to WORD_BITS
	assign full_word = {hi_q, lo_q};
	for (genvar i = 0; i < WORD_W; i++) begin : g_word
		if (i < WORD_BITS && i < FULL_BITS) begin : g_bit
			assign word_asm[i] = full_word[i];
		end else begin : g_zero
			assign word_asm[i] = 1'b0;
		end
	end

	// Saturating line count, digit value from the low bits of '0'..'7'
	assign line_inc = (line_q == '1) ? line_q : line_q + LINE_W'(1);
	assign digit    = char_code[2:0];

	// Next state and result
	always_comb begin
		n_second      = second_q;
		n_cnt         = cnt_q;
		n_tag1        = tag1_q;
		n_tag2        = tag2_q;
		n_hi          = hi_q;
		n_lo          = lo_q;
		n_line        = line_q;
		res_valid     = 1'b0;
		res.status    = ST_OK;
		res.line_number = line_q;
		res.tag       = '0;
		res.word      = '0;
		if (step) begin
			if (op == OP_EOF || char_code == CH_NEWLINE) begin
				// end of line
				if (cnt_q == '0) begin
					n_line = line_inc;
				end else if (cnt_q < CNT_FULL) begin
					res_valid  = 1'b1;
					res.status = ST_TOO_FEW;
					n_second   = 1'b0;
					n_cnt      = '0;
				end else begin
					n_cnt  = '0;
					n_line = line_inc;
					if (!second_q) begin
						n_second = 1'b1;
					end else begin
						res_valid       = 1'b1;
						res.line_number = line_inc;
						res.tag         = {tag2_q, tag1_q};
						res.word        = word_asm;
						n_second        = 1'b0;
					end
				end
				// end of file with nothing reported
				if (op == OP_EOF && !res_valid) begin
					res_valid       = 1'b1;
					res.status      = ST_INCOMPLETE;
					res.line_number = n_line;
					n_second        = 1'b0;
					n_cnt           = '0;
				end
			end else if (char_code inside {[CH_ZERO:CH_NINE]}) begin
				if (char_code > CH_SEVEN) begin
					res_valid  = 1'b1;
					res.status = ST_NON_OCTAL;
					n_second   = 1'b0;
					n_cnt      = '0;
				end else if (cnt_q == CNT_FULL) begin
					res_valid  = 1'b1;
					res.status = ST_TOO_MANY;
					n_second   = 1'b0;
					n_cnt      = '0;
				end else begin
					n_cnt = cnt_q + CNT_ONE;
					if (cnt_q == '0) begin
						if (second_q) begin
							n_tag2 = digit;
						end else begin
							n_tag1 = digit;
						end
					end else if (second_q) begin
						n_lo = ADDR_BITS'({lo_q, digit});
					end else begin
						n_hi = ADDR_BITS'({hi_q, digit});
					end
				end
			end
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			second_q <= 1'b0;
			cnt_q    <= '0;
			line_q   <= LINE_W'(1);
			tag1_q   <= '0;
			tag2_q   <= '0;
			hi_q     <= '0;
			lo_q     <= '0;
		end else begin
			second_q <= n_second;
			cnt_q    <= n_cnt;
			line_q   <= n_line;
			tag1_q   <= n_tag1;
			tag2_q   <= n_tag2;
			hi_q     <= n_hi;
			lo_q     <= n_lo;
		end
	end

endmodule

// File: hdl/octal_word_line_parser.sv
// ----------------------------------------------------------------------------
// octal_word_line_parser
// Octal text line parser that pairs non-blank lines into tagged words.
// ----------------------------------------------------------------------------
// Takes one character (or an end-of-file mark) per beat and gives at most one
// result beat per input beat. An accepted beat is captured in the input
// register and handled against the parser state once the result register can
// take its result, which is registered at the end of that cycle and offered
// from the result register; a new character is taken every cycle as long as
// the result side is not stalled. A stalled, occupied result register holds
// back the input register, which then asserts in_stall.
module octal_word_line_parser #(
	parameter int DIGITS_PER_LINE = olp_pkg::DIGITS_PER_LINE_DEF,
	parameter int WORD_BITS       = olp_pkg::WORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          op,
	input  logic [olp_pkg::CHAR_W-1:0]    char_code,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [olp_pkg::STATUS_W-1:0]  status,
	output logic [olp_pkg::LINE_W-1:0]    line_number,
	output logic [olp_pkg::TAG_W-1:0]     tag,
	output logic [olp_pkg::WORD_W-1:0]    word
);
	import olp_pkg::*;

	logic              valid_s1;
	logic              op_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              out_valid_q;
	result_t           out_q;
	logic              out_free;
	logic              advance;
	logic              accept;
	logic              res_valid;
	result_t           res;

	// Handshake
	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign accept   = in_valid && !in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= op;
			char_s1 <= char_code;
		end
	end

	olp_parse #(
		.DIGITS_PER_LINE(DIGITS_PER_LINE),
		.WORD_BITS(WORD_BITS)
	) u_parse (
		.clk(clk),
		.arst_n(arst_n),
		.step(advance),
		.op(op_s1),
		.char_code(char_s1),
		.res_valid(res_valid),
		.res(res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_q.status;
	assign line_number = out_q.line_number;
	assign tag         = out_q.tag;
	assign word        = out_q.word;

endmodule

// File: hdl/olp_checker.sv
// ----------------------------------------------------------------------------
// olp_checker
// Port-level checks for the octal word line parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module olp_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_stall,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [olp_pkg::STATUS_W-1:0]  status,
	input  logic [olp_pkg::LINE_W-1:0]    line_number,
	input  logic [olp_pkg::TAG_W-1:0]     tag,
	input  logic [olp_pkg::WORD_W-1:0]    word
);
	import olp_pkg::*;

	// A stalled result beat stays
	`OLP_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid, "result beat dropped while stalled")

	// Input backs up only behind a stalled, full result register
	`OLP_ASSERT(a_stall_cause, clk, arst_n, !in_stall || (out_valid && out_stall), "input stalled without output backlog")

	// Error beats carry no record
	`OLP_ASSERT(a_err_clear, clk, arst_n, !out_valid || status == ST_OK || (tag == '0 && word == '0), "error beat carries record data")

	// Lines count from one
	`OLP_ASSERT(a_line_nz, clk, arst_n, !out_valid || line_number != '0, "line number zero")

endmodule

bind octal_word_line_parser olp_checker u_olp_checker (.*);

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for octal_word_line_parser. It sends character and end-of-file
// beats under random idling on both sides. A line-record tracker predicts
// every record and error beat, and each result beat is checked field by field.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import olp_pkg::*;

	localparam int ADDR_W = 3 * (DIGITS_PER_LINE_DEF - 1);
	localparam longint unsigned WORD_MASK = (64'd1 << WORD_BITS_DEF) - 1;
	localparam logic [CHAR_W-1:0] CH_EIGHT = CH_SEVEN + 8'd1;
	localparam int CYCLE_LIMIT = 400_000;

	// Tracks the parse state and holds the result beats still owed by the block
	class line_record_tracker;
		bit                 second_half;
		int unsigned        digit_count;
		logic [2:0]         first_tag;
		logic [2:0]         second_tag;
		logic [ADDR_W-1:0]  high_addr;
		logic [ADDR_W-1:0]  low_addr;
		logic [LINE_W-1:0]  line_count;
		result_t            records[$];
		int unsigned        mismatches;

		function new();
			clear_record();
			line_count = 1;
			mismatches = 0;
		endfunction

		function void clear_record();
			second_half = 1'b0;
			digit_count = 0;
			first_tag = '0;
			second_tag = '0;
			high_addr = '0;
			low_addr = '0;
		endfunction

		// Line counter stops at its top value
		function void advance_line();
			if (line_count != '1)
				line_count++;
		endfunction

		function void post(status_t st, logic [TAG_W-1:0] t, logic [WORD_W-1:0] w);
			result_t r;
			r.status = st;
			r.line_number = line_count;
			r.tag = t;
			r.word = w;
			records.push_back(r);
		endfunction

		// Newline handling; returns 1 when a result beat is owed
		function bit close_line();
			logic [2*ADDR_W-1:0] joined;
			logic [TAG_W-1:0]    rec_tag;
			if (digit_count == 0) begin
				advance_line();
				return 1'b0;
			end
			if (digit_count < DIGITS_PER_LINE_DEF) begin
				clear_record();
				post(ST_TOO_FEW, '0, '0);
				return 1'b1;
			end
			digit_count = 0;
			advance_line();
			if (!second_half) begin
				second_half = 1'b1;
				return 1'b0;
			end
			joined = {high_addr, low_addr};
			rec_tag = {second_tag, first_tag};
			clear_record();
			post(ST_OK, rec_tag, WORD_W'(longint'(joined) & WORD_MASK));
			return 1'b1;
		endfunction

		function void take_beat(logic beat_op, logic [CHAR_W-1:0] ch);
			logic [2:0] d;
			if (beat_op == OP_EOF) begin
				// end of file closes the line first, then flags incomplete if that posted nothing
				if (!close_line()) begin
					clear_record();
					post(ST_INCOMPLETE, '0, '0);
				end
				return;
			end
			if (ch == CH_NEWLINE) begin
				void'(close_line());
				return;
			end
			if (ch < CH_ZERO || ch > CH_NINE)
				return;
			if (ch > CH_SEVEN) begin
				clear_record();
				post(ST_NON_OCTAL, '0, '0);
				return;
			end
			d = 3'(ch - CH_ZERO);
			if (digit_count == 0) begin
				if (second_half)
					second_tag = d;
				else
					first_tag = d;
			end else if (second_half) begin
				low_addr = (low_addr << 3) | ADDR_W'(d);
			end else begin
				high_addr = (high_addr << 3) | ADDR_W'(d);
			end
			digit_count++;
			if (digit_count > DIGITS_PER_LINE_DEF) begin
				clear_record();
				post(ST_TOO_MANY, '0, '0);
			end
		endfunction

		function void match_record(logic [STATUS_W-1:0] st, logic [LINE_W-1:0] ln,
				logic [TAG_W-1:0] t, logic [WORD_W-1:0] w);
			result_t e;
			if (records.size() == 0) begin
				$error("unexpected result beat: status %0d line %0d tag %0d word %0d",
					st, ln, t, w);
				mismatches++;
				return;
			end
			e = records.pop_front();
			if (st !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, st);
				mismatches++;
			end
			if (ln !== e.line_number) begin
				$error("line_number: expected %0d, got %0d", e.line_number, ln);
				mismatches++;
			end
			if (t !== e.tag) begin
				$error("tag: expected %0d, got %0d", e.tag, t);
				mismatches++;
			end
			if (w !== e.word) begin
				$error("word: expected %0d, got %0d", e.word, w);
				mismatches++;
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 op = OP_CHAR;
	logic [CHAR_W-1:0]    char_code = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [STATUS_W-1:0]  status;
	logic [LINE_W-1:0]    line_number;
	logic [TAG_W-1:0]     tag;
	logic [WORD_W-1:0]    word;

	line_record_tracker tracker;
	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned sent_beats = 0;
	int unsigned cycle_count = 0;

	octal_word_line_parser #(
		.DIGITS_PER_LINE(DIGITS_PER_LINE_DEF),
		.WORD_BITS(WORD_BITS_DEF)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.char_code(char_code),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.line_number(line_number),
		.tag(tag),
		.word(word)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Watch both channels; random receiver stall
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				tracker.match_record(status, line_number, tag, word);
			if (in_valid && !in_stall)
				tracker.take_beat(op, char_code);
		end
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("octal_word_line_parser regression: fail");
		$finish;
	end

	// One input beat; valid stays high into the next beat unless an idle gap follows
	task automatic send_beat(input logic beat_op, input logic [CHAR_W-1:0] beat_char);
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		in_valid <= 1'b1;
		op <= beat_op;
		char_code <= beat_char;
		do @(posedge clk); while (in_stall);
		sent_beats++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_beat(OP_CHAR, s[i]);
	endtask

	// Any code the parser skips
	function automatic logic [CHAR_W-1:0] junk_char();
		logic [CHAR_W-1:0] c;
		do c = CHAR_W'($urandom_range(255));
		while (c == CH_NEWLINE || (c >= CH_ZERO && c <= CH_NINE));
		return c;
	endfunction

	function automatic logic [CHAR_W-1:0] digit_char();
		return CH_ZERO + CHAR_W'($urandom_range(7));
	endfunction

	// A line of n digits with scattered junk, closed by newline or end of file
	task automatic send_line(input int unsigned n, input bit close_eof);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(9) == 0)
				send_beat(OP_CHAR, junk_char());
			send_beat(OP_CHAR, digit_char());
		end
		if ($urandom_range(9) == 0)
			send_beat(OP_CHAR, junk_char());
		if (close_eof)
			send_beat(OP_EOF, CHAR_W'($urandom_range(255)));
		else
			send_beat(OP_CHAR, CH_NEWLINE);
	endtask

	task automatic send_blank_lines();
		if ($urandom_range(3) == 0)
			repeat ($urandom_range(1, 2)) send_beat(OP_CHAR, CH_NEWLINE);
	endtask

	// Mostly whole records with random content; the rest broken lines and noise
	task automatic run_random(input int unsigned target);
		int unsigned goal;
		int unsigned pick;
		int unsigned n;
		goal = sent_beats + target;
		while (sent_beats < goal) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				send_blank_lines();
				send_line(DIGITS_PER_LINE_DEF, 1'b0);
				send_blank_lines();
				send_line(DIGITS_PER_LINE_DEF, $urandom_range(9) == 0);
			end else if (pick < 76) begin
				send_line(DIGITS_PER_LINE_DEF, 1'b0);
				send_beat(OP_EOF, CHAR_W'($urandom_range(255)));
			end else if (pick < 84) begin
				n = $urandom_range(1, 5);
				if (n >= DIGITS_PER_LINE_DEF)
					n++;
				send_line(n, $urandom_range(7) == 0);
			end else if (pick < 90) begin
				repeat ($urandom_range(2)) send_beat(OP_CHAR, digit_char());
				send_beat(OP_CHAR, $urandom_range(1) ? CH_NINE : CH_EIGHT);
				send_beat(OP_CHAR, CH_NEWLINE);
			end else if (pick < 96) begin
				repeat ($urandom_range(1, 6))
					send_beat(OP_CHAR, CHAR_W'($urandom_range(255)));
			end else begin
				send_beat(OP_EOF, CHAR_W'($urandom_range(255)));
			end
		end
	endtask

	initial begin
		tracker = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Sender idles lightly, receiver stalls heavily
		idle_pct = 10;
		stall_pct = 76;

		// Directed: empty end of file, extreme digits, record closed by end of file
		send_beat(OP_EOF, 8'hFF);
		send_text("777\n000");
		send_beat(OP_EOF, 8'h00);
		// blank line, 8 and 9, too many digits with the rest read as a new line
		send_text("\n8901234\n");
		// too few, then half a record cut by end of file
		send_text("45\n654\n");
		send_beat(OP_EOF, 8'h5A);
		// short line closed by end of file
		send_text("3");
		send_beat(OP_EOF, 8'hA5);

		run_random(160);

		// Sender idles heavily, receiver stalls lightly
		idle_pct = 76;
		stall_pct = 10;
		run_random(170);

		// Back to back
		idle_pct = 0;
		stall_pct = 0;
		run_random(170);

		// Record, non-octal digit and short line in a row, then end of file
		send_text("123\n456\n8\n71\n");
		send_beat(OP_EOF, 8'h0F);

		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.records.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (tracker.mismatches == 0 && tracker.records.size() == 0)
			$display("octal_word_line_parser regression: pass");
		else
			$display("octal_word_line_parser regression: fail");
		$finish;
	end

endmodule

// File: sim.f
+incdir+hdl
hdl/olp_pkg.sv
hdl/olp_parse.sv
hdl/octal_word_line_parser.sv
hdl/olp_checker.sv
verif/tb.sv
